// ----- sv/wodgs_pkg.sv -----
// Shared types, constants and helper functions of the wheel odometry steering block.
package wodgs_pkg;

   localparam int MUL_W  = 34;
   localparam int PROD_W = 68;

   localparam logic signed [MUL_W-1:0] K_LEFT_C      = 34'sd14571578;
   localparam logic signed [MUL_W-1:0] K_RIGHT_C     = 34'sd15203411;
   localparam logic signed [MUL_W-1:0] INV_WB_C      = 34'sd1095654922;
   localparam logic signed [MUL_W-1:0] STEER_SCALE_C = 34'sd25478;
   localparam logic signed [MUL_W-1:0] RECIP10_C     = 34'sd3435973837;

   localparam logic signed [31:0] CORDIC_GAIN_C = 32'sd652032874;
   localparam logic signed [20:0] PI_Q16        = 21'sd205887;
   localparam logic signed [20:0] HALF_PI_Q16   = 21'sd102944;
   localparam logic signed [20:0] TWO_PI_Q16    = 21'sd411775;
   localparam logic [31:0]        TWO_PI_U      = 32'd411775;
   localparam logic [3:0]         MOD_STEPS     = 4'd12;
   localparam logic [17:0]        STEER_LIMIT_U = 18'd20000;

   localparam logic [1:0] REG_GOAL_X       = 2'd0;
   localparam logic [1:0] REG_GOAL_Y       = 2'd1;
   localparam logic [1:0] REG_GOAL_HEADING = 2'd2;

   localparam logic [1:0] SPEED_LOW  = 2'd1;
   localparam logic [1:0] SPEED_HIGH = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE, S_MUL_L, S_MUL_R, S_MUL_H, S_MOD_INIT, S_MOD, S_FOLD, S_ROT,
      S_POSX, S_POSY, S_POSW, S_VLOAD, S_NORM, S_VEC, S_ANG, S_SCALE,
      S_DIV10, S_DX2, S_DY2, S_SPEED
   } wodgs_state_type;

   typedef enum logic [2:0] {
      CORD_HOLD, CORD_LOAD, CORD_ROT, CORD_VEC, CORD_SHR, CORD_SHL
   } wodgs_cord_op_type;

   typedef struct packed {
      wodgs_cord_op_type op;
      logic [4:0]        idx;
   } wodgs_cord_ctrl_type;

   function automatic logic signed [31:0] cordic_angle(input logic [4:0] i);
      logic signed [31:0] r;
      unique case (i)
         5'd0:    r = 32'sd843314857;
         5'd1:    r = 32'sd497837829;
         5'd2:    r = 32'sd263043837;
         5'd3:    r = 32'sd133525159;
         5'd4:    r = 32'sd67021688;
         5'd5:    r = 32'sd33543516;
         5'd6:    r = 32'sd16775851;
         5'd7:    r = 32'sd8388437;
         5'd8:    r = 32'sd4194283;
         5'd9:    r = 32'sd2097149;
         5'd10:   r = 32'sd1048576;
         5'd11:   r = 32'sd524288;
         default: r = (i <= 5'd30) ? (32'sd1 <<< (5'd30 - i)) : 32'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ----- sv/wodgs_mul.sv -----
// Shared signed multiplier with registered product.
module wodgs_mul (
   input  logic                                  clock,
   input  logic signed [wodgs_pkg::MUL_W-1:0]    a,
   input  logic signed [wodgs_pkg::MUL_W-1:0]    b,
   output logic signed [wodgs_pkg::PROD_W-1:0]   prod
);
   import wodgs_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = a * b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- sv/wodgs_cordic.sv -----
// Iterative CORDIC unit: rotation, vectoring and normalizing shifts.
module wodgs_cordic #(
   parameter int CW = 36
) (
   input  logic                            clock,
   input  wodgs_pkg::wodgs_cord_ctrl_type  ctrl,
   input  logic signed [CW-1:0]            load_x,
   input  logic signed [CW-1:0]            load_y,
   input  logic signed [CW-1:0]            load_z,
   output logic signed [CW-1:0]            x,
   output logic signed [CW-1:0]            y,
   output logic signed [CW-1:0]            z
);
   import wodgs_pkg::*;

   logic signed [CW-1:0] x_ff, y_ff, z_ff;
   logic signed [CW-1:0] x_in, y_in, z_in;
   logic signed [CW-1:0] xs, ys, ang;
   logic                 dir;

   always_comb begin
      xs  = x_ff >>> ctrl.idx;
      ys  = y_ff >>> ctrl.idx;
      ang = CW'(cordic_angle(ctrl.idx));
      dir = (ctrl.op == CORD_ROT) ? !z_ff[CW-1] : y_ff[CW-1];
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      unique case (ctrl.op)
         CORD_HOLD: begin
         end
         CORD_LOAD: begin
            x_in = load_x;
            y_in = load_y;
            z_in = load_z;
         end
         CORD_ROT, CORD_VEC: begin
            if (dir) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - ang;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + ang;
            end
         end
         CORD_SHR: begin
            x_in = x_ff >>> 1;
            y_in = y_ff >>> 1;
         end
         CORD_SHL: begin
            x_in = x_ff <<< 1;
            y_in = y_ff <<< 1;
         end
         default: begin
         end
      endcase
   end

   assign x = x_ff;
   assign y = y_ff;
   assign z = z_ff;

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

endmodule

// ----- sv/wheel_odometry_goal_steering.sv -----
// The goal vector is shifted to normalize it before vectoring; a goal with no x offset
//   from the position skips normalizing and vectoring.
// A request is taken only once the previous one is finished; the sequencer waits in its
//   last state while the result register is full.
// A finished result waits in the output register while the next request is taken.
// Reset: synchronous, clears goals, wheel distances, position, speed level and control.
module wheel_odometry_goal_steering #(
   parameter int CORDIC_ITERATIONS = 16,
   parameter int POSITION_WIDTH    = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,   // left_ticks[31:0], right_ticks[63:32]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [119:0]  rsp_tdata,   // x_position[31:0], y_position[63:32],
                                      // heading[95:64], steering_command[111:96],
                                      // speed_level[113:112], zero fill
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [3:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);
   import wodgs_pkg::*;

   localparam int PW = POSITION_WIDTH;
   localparam int DW = ((PW > 32) ? PW : 32) + 1;
   localparam int CW = ((DW + 1) > 36) ? DW + 1 : 36;
   localparam int IW = $clog2(CORDIC_ITERATIONS);
   localparam logic [IW-1:0] LAST_IT = IW'(CORDIC_ITERATIONS - 1);
   localparam logic signed [CW-1:0] M31 = CW'(64'sd2147483648);
   localparam logic signed [CW-1:0] M30 = CW'(64'sd1073741824);
   localparam logic signed [DW-1:0] LIM17 = DW'(64'sd131072);

   wodgs_state_type state_ff, state_in;

   logic signed [31:0]   goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic signed [18:0]   goal_h_ff, goal_h_in;
   logic signed [31:0]   lt_ff, lt_in, rt_ff, rt_in, ld_ff, ld_in;
   logic signed [31:0]   prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   logic signed [31:0]   half_ff, half_in, h_ff, h_in;
   logic [31:0]          red_ff, red_in;
   logic                 red_neg_ff, red_neg_in, neg_ff, neg_in;
   logic [3:0]           k_ff, k_in;
   logic [IW-1:0]        cnt_ff, cnt_in;
   logic signed [PW-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [DW-1:0] fx_ff, fx_in, fy_ff, fy_in;
   logic signed [19:0]   ang_ff, ang_in;
   logic                 big_ff, big_in, num_neg_ff, num_neg_in;
   logic signed [15:0]   steer_ff, steer_in;
   logic [35:0]          sq_ff, sq_in;
   logic [1:0]           speed_ff, speed_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]   rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_h_ff, rsp_h_in;
   logic signed [15:0]   rsp_steer_ff, rsp_steer_in;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;
   wodgs_cord_ctrl_type      cord_ctrl;
   logic signed [CW-1:0]     load_x, load_y, load_z, cx, cy, cz;

   logic signed [31:0] rd_c, h_c;
   logic signed [33:0] sum_c, xi_c;
   logic signed [20:0] a_c;
   logic signed [21:0] pt_c;
   logic signed [43:0] num_c, num_mag_c;
   logic signed [DW-1:0] fx_c, fy_c;
   logic signed [CW-1:0] ay_c, m_c, c_c, s_c;
   logic [17:0]          q_c, smag_c;
   logic [36:0]          d2_c;
   logic                 csr_wr, small_c, slot_free;

   wodgs_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   wodgs_cordic #(.CW(CW)) u_cordic (
      .clock  (clock),
      .ctrl   (cord_ctrl),
      .load_x (load_x),
      .load_y (load_y),
      .load_z (load_z),
      .x      (cx),
      .y      (cy),
      .z      (cz)
   );

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_GOAL_X:       csr_prdata = goal_x_ff;
         REG_GOAL_Y:       csr_prdata = goal_y_ff;
         REG_GOAL_HEADING: csr_prdata = 32'(goal_h_ff);
         default:          csr_prdata = 32'd0;
      endcase
   end

   // combinational helpers
   always_comb begin
      rd_c  = sat32(64'($signed(prod[67:16])));
      sum_c = 34'(ld_ff) - 34'(prev_l_ff) + 34'(rd_c) - 34'(prev_r_ff);
      h_c   = sat32(64'($signed(prod[67:30])));
      a_c   = red_neg_ff ? -21'(red_ff) : 21'(red_ff);
      fx_c  = DW'(goal_x_ff) - DW'(pos_x_ff);
      fy_c  = DW'(goal_y_ff) - DW'(pos_y_ff);
      ay_c  = cy[CW-1] ? -cy : cy;
      m_c   = (cx > ay_c) ? cx : ay_c;
      c_c   = neg_ff ? -cx : cx;
      s_c   = neg_ff ? -cy : cy;
      xi_c  = 34'(ang_ff) - 34'(h_ff);
      pt_c  = 22'(goal_h_ff) - 22'(ang_ff);
      num_c = 44'(xi_c) * 44'sd46 - 44'(pt_c) * 44'sd28;
      num_mag_c = num_c[43] ? -num_c : num_c;
      q_c    = prod[52:35];
      smag_c = (big_ff || q_c > STEER_LIMIT_U) ? STEER_LIMIT_U : q_c;
      small_c = (fx_ff < LIM17) && (fx_ff > -LIM17) && (fy_ff < LIM17) && (fy_ff > -LIM17);
      d2_c   = 37'(sq_ff) + 37'(prod[35:0]);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (req_tvalid) state_in = S_MUL_L;
         S_MUL_L:    state_in = S_MUL_R;
         S_MUL_R:    state_in = S_MUL_H;
         S_MUL_H:    state_in = S_MOD_INIT;
         S_MOD_INIT: state_in = S_MOD;
         S_MOD:      if (k_ff == 4'd0) state_in = S_FOLD;
         S_FOLD:     state_in = S_ROT;
         S_ROT:      if (cnt_ff == LAST_IT) state_in = S_POSX;
         S_POSX:     state_in = S_POSY;
         S_POSY:     state_in = S_POSW;
         S_POSW:     state_in = S_VLOAD;
         S_VLOAD:    state_in = (fx_c == '0) ? S_SCALE : S_NORM;
         S_NORM:     if (m_c < M31 && m_c >= M30) state_in = S_VEC;
         S_VEC:      if (cnt_ff == LAST_IT) state_in = S_ANG;
         S_ANG:      state_in = S_SCALE;
         S_SCALE:    state_in = S_DIV10;
         S_DIV10:    state_in = S_DX2;
         S_DX2:      state_in = S_DY2;
         S_DY2:      state_in = S_SPEED;
         S_SPEED:    if (slot_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // unit controls
   always_comb begin
      req_tready    = 1'b0;
      mul_a         = '0;
      mul_b         = '0;
      cord_ctrl.op  = CORD_HOLD;
      cord_ctrl.idx = 5'(cnt_ff);
      load_x        = '0;
      load_y        = '0;
      load_z        = '0;
      unique case (state_ff)
         S_IDLE:  req_tready = 1'b1;
         S_MUL_L: begin
            mul_a = 34'(lt_ff);
            mul_b = K_LEFT_C;
         end
         S_MUL_R: begin
            mul_a = 34'(rt_ff);
            mul_b = K_RIGHT_C;
         end
         S_MUL_H: begin
            mul_a = 34'(rd_c) - 34'(ld_ff);
            mul_b = INV_WB_C;
         end
         S_FOLD: begin
            cord_ctrl.op = CORD_LOAD;
            load_x = CW'(CORDIC_GAIN_C);
         end
         S_ROT:  cord_ctrl.op = CORD_ROT;
         S_POSX: begin
            mul_a = 34'(half_ff);
            mul_b = 34'(c_c);
         end
         S_POSY: begin
            mul_a = 34'(half_ff);
            mul_b = 34'(s_c);
         end
         S_VLOAD: begin
            cord_ctrl.op = CORD_LOAD;
            load_x = fx_c[DW-1] ? -CW'(fx_c) : CW'(fx_c);
            load_y = fx_c[DW-1] ? -CW'(fy_c) : CW'(fy_c);
         end
         S_NORM: begin
            if (m_c >= M31) begin
               cord_ctrl.op = CORD_SHR;
            end else if (m_c < M30) begin
               cord_ctrl.op = CORD_SHL;
            end
         end
         S_VEC:   cord_ctrl.op = CORD_VEC;
         S_SCALE: begin
            mul_a = 34'(num_mag_c);
            mul_b = STEER_SCALE_C;
         end
         S_DIV10: begin
            mul_a = 34'(prod[36:16]);
            mul_b = RECIP10_C;
         end
         S_DX2: begin
            mul_a = 34'(fx_ff);
            mul_b = 34'(fx_ff);
         end
         S_DY2: begin
            mul_a = 34'(fy_ff);
            mul_b = 34'(fy_ff);
         end
         S_SPEED: begin
            mul_a = 34'(fy_ff);
            mul_b = 34'(fy_ff);
         end
         default: begin
         end
      endcase
      if (state_ff == S_FOLD) begin
         load_z = CW'(a_c);
         if (a_c > PI_Q16) begin
            load_z = CW'(a_c - TWO_PI_Q16);
         end else if (a_c < -PI_Q16) begin
            load_z = CW'(a_c + TWO_PI_Q16);
         end
         if (load_z > CW'(HALF_PI_Q16)) begin
            load_z = load_z - CW'(PI_Q16);
         end else if (load_z < -CW'(HALF_PI_Q16)) begin
            load_z = load_z + CW'(PI_Q16);
         end
         load_z = load_z <<< 14;
      end
   end

   // datapath
   always_comb begin
      goal_x_in = goal_x_ff;  goal_y_in = goal_y_ff;  goal_h_in = goal_h_ff;
      lt_in = lt_ff;  rt_in = rt_ff;  ld_in = ld_ff;
      prev_l_in = prev_l_ff;  prev_r_in = prev_r_ff;
      half_in = half_ff;  h_in = h_ff;  red_in = red_ff;  red_neg_in = red_neg_ff;
      neg_in = neg_ff;  k_in = k_ff;  cnt_in = cnt_ff;
      pos_x_in = pos_x_ff;  pos_y_in = pos_y_ff;  fx_in = fx_ff;  fy_in = fy_ff;
      ang_in = ang_ff;  big_in = big_ff;  num_neg_in = num_neg_ff;
      steer_in = steer_ff;  sq_in = sq_ff;  speed_in = speed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_x_in = rsp_x_ff;  rsp_y_in = rsp_y_ff;  rsp_h_in = rsp_h_ff;
      rsp_steer_in = rsp_steer_ff;

      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_GOAL_X:       goal_x_in = csr_pwdata;
            REG_GOAL_Y:       goal_y_in = csr_pwdata;
            REG_GOAL_HEADING: goal_h_in = csr_pwdata[18:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            lt_in = req_tdata[31:0];
            rt_in = req_tdata[63:32];
         end
         S_MUL_R: ld_in = rd_c;
         S_MUL_H: begin
            half_in   = sat32(64'(sum_c >>> 1));
            prev_l_in = ld_ff;
            prev_r_in = rd_c;
         end
         S_MOD_INIT: begin
            h_in       = h_c;
            red_neg_in = h_c[31];
            red_in     = h_c[31] ? 32'(-h_c) : 32'(h_c);
            k_in       = MOD_STEPS;
         end
         S_MOD: begin
            if (red_ff >= (TWO_PI_U << k_ff)) red_in = red_ff - (TWO_PI_U << k_ff);
            k_in = k_ff - 4'd1;
         end
         S_FOLD: begin
            cnt_in = '0;
            neg_in = 1'b0;
            if (a_c > HALF_PI_Q16 + TWO_PI_Q16 || a_c < -HALF_PI_Q16 - TWO_PI_Q16) begin
               neg_in = 1'b0;
            end else if ((a_c > HALF_PI_Q16 && a_c <= PI_Q16)
                         || (a_c < -HALF_PI_Q16 && a_c >= -PI_Q16)) begin
               neg_in = 1'b1;
            end
         end
         S_ROT, S_VEC: cnt_in = cnt_ff + IW'(1);
         S_POSY: pos_x_in = pos_x_ff + PW'($signed(prod[67:30]));
         S_POSW: pos_y_in = pos_y_ff + PW'($signed(prod[67:30]));
         S_VLOAD: begin
            fx_in  = fx_c;
            fy_in  = fy_c;
            cnt_in = '0;
            if (fy_c > 0) begin
               ang_in = 20'(HALF_PI_Q16);
            end else if (fy_c < 0) begin
               ang_in = -20'(HALF_PI_Q16);
            end else begin
               ang_in = '0;
            end
         end
         S_ANG: ang_in = 20'((cz + CW'(8192)) >>> 14);
         S_SCALE: begin
            big_in     = (num_c > 44'sd1048576) || (num_c < -44'sd1048576);
            num_neg_in = num_c[43];
         end
         S_DX2: steer_in = num_neg_ff ? -16'(smag_c) : 16'(smag_c);
         S_DY2: sq_in = prod[35:0];
         S_SPEED: begin
            if (slot_free) begin
               if (!small_c || d2_c > 37'h100000000) begin
                  speed_in = SPEED_HIGH;
               end else if (d2_c < 37'h100000000 && d2_c != 37'd0) begin
                  speed_in = SPEED_LOW;
               end
               rsp_valid_in = 1'b1;
               rsp_x_in     = 32'(pos_x_ff);
               rsp_y_in     = 32'(pos_y_ff);
               rsp_h_in     = h_ff;
               rsp_steer_in = steer_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // the fold flag follows the reduced angle: recompute it exactly here
   logic fold_neg_c;
   logic signed [20:0] a1_c;
   always_comb begin
      a1_c = a_c;
      if (a_c > PI_Q16) begin
         a1_c = a_c - TWO_PI_Q16;
      end else if (a_c < -PI_Q16) begin
         a1_c = a_c + TWO_PI_Q16;
      end
      fold_neg_c = (a1_c > HALF_PI_Q16) || (a1_c < -HALF_PI_Q16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         goal_h_ff    <= '0;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         speed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         goal_x_ff    <= goal_x_in;
         goal_y_ff    <= goal_y_in;
         goal_h_ff    <= goal_h_in;
         prev_l_ff    <= prev_l_in;
         prev_r_ff    <= prev_r_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         speed_ff     <= speed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lt_ff        <= lt_in;
      rt_ff        <= rt_in;
      ld_ff        <= ld_in;
      half_ff      <= half_in;
      h_ff         <= h_in;
      red_ff       <= red_in;
      red_neg_ff   <= red_neg_in;
      neg_ff       <= (state_ff == S_FOLD) ? fold_neg_c : neg_in;
      k_ff         <= k_in;
      cnt_ff       <= cnt_in;
      fx_ff        <= fx_in;
      fy_ff        <= fy_in;
      ang_ff       <= ang_in;
      big_ff       <= big_in;
      num_neg_ff   <= num_neg_in;
      steer_ff     <= steer_in;
      sq_ff        <= sq_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_h_ff     <= rsp_h_in;
      rsp_steer_ff <= rsp_steer_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, speed_ff, rsp_steer_ff, rsp_h_ff, rsp_y_ff, rsp_x_ff};

`ifndef ASSERT_OFF
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_MUL_L && !req_tready))
      else $error("request accepted but sequencer did not start");

   a_mod_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOD) |-> (k_ff <= MOD_STEPS))
      else $error("heading reduction step out of range");

   a_steer_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_steer_ff <= 16'sd20000 && rsp_steer_ff >= -16'sd20000))
      else $error("steering command beyond limit");
`endif

endmodule
